// ----- src/wtc_pkg.sv -----
// Package for the waypoint turn counter: widths, constants, the CORDIC arctangent
// table and the request struct for the shared CORDIC unit.
// No dependencies.
package wtc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int COUNT_WIDTH  = 16;
  localparam int XW           = 36;
  localparam int VW           = 33;

  // reciprocal of 3515625 / 2^22, scaled by 2^54, rounded down and up
  localparam logic [54:0]   BAM_MUL_DN    = 55'd21492014570926740;
  localparam logic [54:0]   BAM_MUL_UP    = 55'd21492014570926741;
  localparam logic [XW-1:0] CORDIC_GAIN   = XW'(652032874);
  localparam logic [15:0]   THRESH_RESET  = 16'd5461;
  localparam logic [31:0]   QUARTER_TURN  = 32'h4000_0000;
  localparam logic [31:0]   HALF_TURN     = 32'h8000_0000;
  localparam logic [31:0]   ROUND_HALF    = 32'h0000_8000;
  localparam logic [15:0]   TURN_HALF     = 16'h8000;

  typedef struct packed {
    logic                 vec;
    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] y0;
    logic [31:0]          z0;
  } cordic_req_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:    r = 32'h20000000;
        5'd1:    r = 32'h12E4051D;
        5'd2:    r = 32'h09FB385B;
        5'd3:    r = 32'h051111D4;
        5'd4:    r = 32'h028B0D43;
        5'd5:    r = 32'h0145D7E1;
        5'd6:    r = 32'h00A2F61E;
        5'd7:    r = 32'h00517C55;
        5'd8:    r = 32'h0028BE53;
        5'd9:    r = 32'h00145F2E;
        5'd10:   r = 32'h000A2F98;
        5'd11:   r = 32'h000517CC;
        5'd12:   r = 32'h00028BE6;
        5'd13:   r = 32'h000145F3;
        5'd14:   r = 32'h0000A2F9;
        5'd15:   r = 32'h0000517C;
        5'd16:   r = 32'h000028BE;
        5'd17:   r = 32'h0000145F;
        5'd18:   r = 32'h00000A2F;
        5'd19:   r = 32'h00000517;
        5'd20:   r = 32'h0000028B;
        5'd21:   r = 32'h00000145;
        5'd22:   r = 32'h000000A2;
        5'd23:   r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- src/wtc_cordic.sv -----
// Shared iterative CORDIC unit, rotation or vectoring mode, one step per cycle.
// Depends on wtc_pkg.
module wtc_cordic import wtc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  cordic_req_t          req,
  output logic                 busy,
  output logic                 done,
  output logic signed [XW-1:0] x,
  output logic signed [XW-1:0] y,
  output logic [31:0]          z
);

  logic signed [XW-1:0] x_r, y_r, xs, ys, x_nxt, y_nxt;
  logic [31:0]          z_r, at, z_nxt;
  logic [4:0]           cnt_r;
  logic                 vec_r, busy_r, done_r, pos;

  always_comb begin
    xs  = x_r >>> cnt_r;
    ys  = y_r >>> cnt_r;
    at  = atan_bam(cnt_r);
    pos = vec_r ? y_r[XW-1] : !z_r[31];
    if (pos) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        vec_r  <= req.vec;
        x_r    <= req.x0;
        y_r    <= req.y0;
        z_r    <= req.z0;
      end else if (busy_r) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        z_r <= z_nxt;
        if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 5'd1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;

endmodule

// ----- src/waypoint_turn_counter_core.sv -----
// Waypoint turn counter: great-circle bearing per segment and thresholded turn count.
// Sequence: reciprocal-multiply angle conversion, ending a path start or repeated point;
// a segment adds three CORDIC rotations, multiply steps and a vectoring pass (not for a
// zero vector). One transaction at a time; the next accept can follow in the cycle after
// the result is registered. The shared CORDIC bounds the rate; a held result stalls the next one.
// Reset (rst_n low, synchronous): threshold 5461, path state and counters cleared.
// Depends on wtc_pkg and wtc_cordic.
module waypoint_turn_counter_core import wtc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // latitude[30:0], longitude[62:31], zero pad
  input  logic        in_tuser,   // new_path
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // bearing[15:0], turn_angle[31:16], turn_count[47:32]
  output logic [1:0]  out_tuser,  // bearing_valid[0], is_turn[1]
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_CONV, S_SC_L1, S_SC_L2, S_SC_DL, S_MUL, S_VEC, S_DONE
  } state_t;

  state_t state_r;

  logic [15:0] thr_r;
  logic signed [30:0] lat_r, plat_r;
  logic [31:0] lon_r, plon_r;
  logic [31:0] bl_r, bn_r, pbl_r, pbn_r;
  logic        first_r;
  logic [1:0]  pts_r;
  logic [COUNT_WIDTH-1:0] chg_r;
  logic [15:0] pbear_r, bear_r;

  logic [1:0]  cstep_r;
  logic [63:0] plo_r, cprod;
  logic        cneg;
  logic [31:0] cmag, mop, cq, cres;
  logic [54:0] magic;
  logic [95:0] csum;

  logic        launched_r, flip_r, cord_start, cord_busy, cord_done;
  cordic_req_t req;
  logic signed [XW-1:0] cx, cy;
  logic [31:0] cz, ang, zz;
  logic signed [XW-1:0] csin, ccos;

  logic signed [VW-1:0] s1_r, c1_r, s2_r, c2_r, sd_r, cd_r, t1_r, t2_r, ma, mb;
  logic signed [2*VW-1:0] mp_r, mp_sh;
  logic [2:0]  mcnt_r;
  logic signed [XW-1:0] yy_r, xx_r, x_fin;

  logic [15:0] turn_raw, turn_nxt;
  logic        is_turn_nxt;
  logic [COUNT_WIDTH-1:0] chg_nxt;
  logic        out_free;

  function automatic logic [31:0] mag32(input logic [31:0] u);
    return u[31] ? (~u + 32'd1) : u;
  endfunction

  // angle conversion: even step low partial product, odd step high part and result
  always_comb begin
    cneg  = cstep_r[1] ? lon_r[31] : lat_r[30];
    cmag  = mag32(cstep_r[1] ? lon_r : {lat_r[30], lat_r});
    magic = cneg ? BAM_MUL_DN : BAM_MUL_UP;
    mop   = cstep_r[0] ? {9'd0, magic[54:32]} : magic[31:0];
    cprod = cmag * mop;
    csum  = {cprod, 32'd0} + {32'd0, plo_r} + (cneg ? {42'd0, {54{1'b1}}} : 96'd0);
    cq    = csum[85:54];
    cres  = cneg ? (~cq + 32'd1) : cq;
  end

  always_comb begin
    case (state_r)
      S_SC_L1: ang = pbl_r;
      S_SC_L2: ang = bl_r;
      default: ang = bn_r - pbn_r;
    endcase
    cord_start = !launched_r &&
                 (state_r == S_SC_L1 || state_r == S_SC_L2 ||
                  state_r == S_SC_DL || state_r == S_VEC);
    if (state_r == S_VEC) begin
      req.vec = 1'b1;
      req.x0  = xx_r[XW-1] ? -xx_r : xx_r;
      req.y0  = xx_r[XW-1] ? -yy_r : yy_r;
      req.z0  = xx_r[XW-1] ? HALF_TURN : 32'd0;
    end else begin
      req.vec = 1'b0;
      req.x0  = CORDIC_GAIN;
      req.y0  = '0;
      req.z0  = ((ang + QUARTER_TURN) & HALF_TURN) != 32'd0 ? (ang ^ HALF_TURN) : ang;
    end
    csin = flip_r ? -cy : cy;
    ccos = flip_r ? -cx : cx;
    zz   = cz + ROUND_HALF;
  end

  wtc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .req   (req),
    .busy  (cord_busy),
    .done  (cord_done),
    .x     (cx),
    .y     (cy),
    .z     (cz)
  );

  always_comb begin
    case (mcnt_r)
      3'd0:    begin ma = sd_r; mb = c2_r; end
      3'd1:    begin ma = c1_r; mb = s2_r; end
      3'd2:    begin ma = s1_r; mb = c2_r; end
      default: begin ma = t2_r; mb = cd_r; end
    endcase
    mp_sh = mp_r >>> 30;
    x_fin = XW'(t1_r) - XW'(mp_sh);
  end

  always_comb begin
    turn_raw    = bear_r - pbear_r;
    turn_nxt    = (turn_raw > TURN_HALF) ? (~turn_raw + 16'd1) : turn_raw;
    is_turn_nxt = (pts_r == 2'd2) && (turn_nxt > thr_r);
    chg_nxt     = (is_turn_nxt && chg_r != '1) ? chg_r + 1'b1 : chg_r;
    out_free    = !out_tvalid || out_tready;
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      thr_r      <= THRESH_RESET;
      plat_r     <= '0;
      plon_r     <= '0;
      pbl_r      <= '0;
      pbn_r      <= '0;
      pbear_r    <= '0;
      pts_r      <= '0;
      chg_r      <= '0;
      launched_r <= 1'b0;
      out_tvalid <= 1'b0;
      cstep_r    <= '0;
      mcnt_r     <= '0;
    end else begin
      if (cfg_we)
        thr_r <= cfg_wdata;
      if (out_tvalid && out_tready && state_r != S_DONE)
        out_tvalid <= 1'b0;
      if (cord_start) begin
        launched_r <= 1'b1;
        flip_r     <= ((ang + QUARTER_TURN) & HALF_TURN) != 32'd0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            lat_r   <= in_tdata[30:0];
            lon_r   <= in_tdata[62:31];
            first_r <= in_tuser || (pts_r == 2'd0);
            cstep_r <= '0;
            state_r <= S_CONV;
          end
        end
        S_CONV: begin
          cstep_r <= cstep_r + 2'd1;
          if (!cstep_r[0]) begin
            plo_r <= cprod;
          end else if (!cstep_r[1]) begin
            bl_r <= cres;
          end else begin
            bn_r <= cres;
            if (first_r) begin
              state_r <= S_DONE;
            end else if (lat_r == plat_r && lon_r == plon_r) begin
              bear_r  <= '0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_SC_L1;
            end
          end
        end
        S_SC_L1, S_SC_L2, S_SC_DL: begin
          if (cord_done) begin
            launched_r <= 1'b0;
            case (state_r)
              S_SC_L1: begin
                s1_r <= VW'(csin); c1_r <= VW'(ccos); state_r <= S_SC_L2;
              end
              S_SC_L2: begin
                s2_r <= VW'(csin); c2_r <= VW'(ccos); state_r <= S_SC_DL;
              end
              default: begin
                sd_r <= VW'(csin); cd_r <= VW'(ccos); mcnt_r <= '0; state_r <= S_MUL;
              end
            endcase
          end
        end
        S_MUL: begin
          mp_r   <= ma * mb;
          mcnt_r <= mcnt_r + 3'd1;
          case (mcnt_r)
            3'd1:    yy_r <= XW'(mp_sh);
            3'd2:    t1_r <= VW'(mp_sh);
            3'd3:    t2_r <= VW'(mp_sh);
            3'd5: begin
              xx_r <= x_fin;
              if (x_fin == '0 && yy_r == '0) begin
                bear_r  <= '0;
                state_r <= S_DONE;
              end else begin
                state_r <= S_VEC;
              end
            end
            default: ;
          endcase
        end
        S_VEC: begin
          if (cord_done) begin
            launched_r <= 1'b0;
            bear_r     <= zz[31:16];
            state_r    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_tvalid <= 1'b1;
            plat_r     <= lat_r;
            plon_r     <= lon_r;
            pbl_r      <= bl_r;
            pbn_r      <= bn_r;
            state_r    <= S_IDLE;
            if (first_r) begin
              pts_r     <= 2'd1;
              chg_r     <= '0;
              out_tdata <= '0;
              out_tuser <= '0;
            end else begin
              pts_r     <= 2'd2;
              chg_r     <= chg_nxt;
              pbear_r   <= bear_r;
              out_tdata <= {16'(chg_nxt), (pts_r == 2'd2) ? turn_nxt : 16'd0, bear_r};
              out_tuser <= {is_turn_nxt, 1'b1};
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_turn_needs_bearing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser[1] || out_tuser[0]))
    else $error("turn flagged without a valid bearing");

  a_turn_folded: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:16] <= TURN_HALF))
    else $error("turn angle beyond half turn");

  a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !cord_busy)
    else $error("transaction accepted while CORDIC busy");

  a_first_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == 48'd0))
    else $error("path start result not cleared");

endmodule
